@@ rtl/aar_pkg.sv @@
// ----------------------------------------------------------------------------
// aar_pkg
// Shared types and constants for the accessory authentication response block.
// ----------------------------------------------------------------------------
`default_nettype none

package aar_pkg;

    localparam int AreaBytes  = 16;
    localparam int ShiftBytes = 12;
    localparam int ChalBytes  = 4;
    localparam int ChalBase   = 12;

    localparam logic [7:0] MATCH_CODE = 8'h2c;

    // combine select codes, taken from (byte & 6) >> 1
    localparam logic [1:0] SEL_OR  = 2'd0;
    localparam logic [1:0] SEL_AND = 2'd3;

    // mix select codes, taken from byte15 & 3
    localparam logic [1:0] MIX_XOR_A = 2'd1;
    localparam logic [1:0] MIX_XOR_B = 2'd2;

    typedef logic [AreaBytes-1:0][7:0] area_t;

    typedef struct packed {
        logic [31:0] challenge;
        logic [31:0] type_digits;
        logic [63:0] serial_digits;
    } req_t;

    typedef struct packed {
        logic [63:0] response_high;
        logic [63:0] response_low;
    } resp_t;

endpackage

`default_nettype wire

@@ rtl/aar_mix.sv @@
// ----------------------------------------------------------------------------
// aar_mix
// Builds the work area from a request, applies the conditional shift and
// folds the challenge in at its offset.
// ----------------------------------------------------------------------------
`default_nettype none

module aar_mix (
    input  wire aar_pkg::req_t  req,
    output aar_pkg::area_t      area
);
    import aar_pkg::*;

    area_t      orig;
    area_t      shifted;
    logic [2:0] off;
    logic       use_xor;
    logic [3:0] rel;

    assign orig = {req.challenge, req.type_digits, req.serial_digits};

    always_comb begin
        shifted = orig;
        for (int k = 0; k < ShiftBytes; k++) begin
            if (orig[k+1][0]) begin
                shifted[k] = {orig[k][6:0], 1'b0};
            end
        end
    end

    // bytes 12..15 are untouched by the shift, so selection reads orig
    assign use_xor = (orig[15][1:0] == MIX_XOR_A) || (orig[15][1:0] == MIX_XOR_B);
    assign off     = use_xor ? orig[13][2:0] : orig[14][2:0];

    always_comb begin
        area = shifted;
        rel  = '0;
        for (int k = 0; k < ShiftBytes; k++) begin
            // distance from offset; wraps high when k is below it
            rel = 4'(k) - {1'b0, off};
            if (rel < 4'(ChalBytes)) begin
                if (use_xor) begin
                    area[k] = shifted[k] ^ orig[ChalBase + int'(rel[1:0])];
                end else begin
                    area[k] = shifted[k] | orig[ChalBase + int'(rel[1:0])];
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/aar_combine.sv @@
// ----------------------------------------------------------------------------
// aar_combine
// Combines each work byte with the check byte into the response bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module aar_combine (
    input  wire aar_pkg::area_t area,
    input  wire [7:0]           chk,
    output aar_pkg::resp_t      resp
);
    import aar_pkg::*;

    area_t      r;
    logic [1:0] sel;

    always_comb begin
        r   = '0;
        sel = '0;
        for (int i = 0; i < AreaBytes; i++) begin
            sel = area[AreaBytes-1-i][2:1];
            case (sel)
                SEL_OR:  r[i] = area[i] | chk;
                SEL_AND: r[i] = area[i] & chk;
                default: r[i] = area[i] ^ chk;
            endcase
            if (r[i] == chk) begin
                r[i] = MATCH_CODE;
            end
            if (area[i] == 8'h00) begin
                r[i] = 8'h00;
            end
        end
    end

    assign resp.response_low  = r[7:0];
    assign resp.response_high = r[15:8];

endmodule

`default_nettype wire

@@ rtl/accessory_auth_response.sv @@
// ----------------------------------------------------------------------------
// accessory_auth_response
// Three-stage pipeline computing the 16-byte accessory authentication
// response from twelve identity bytes and four challenge bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one request beat: serial and type digits
//   plus the four challenge bytes. m_valid/m_ready/m_data carry one
//   response beat per request, in request order.
//   A request beat passes three registered stages: stage one shifts and
//   mixes the work area, stage two forms the check byte, stage three
//   combines bytes into the output register.
//   One beat per cycle while m_ready is high; the combine stage bounds the clock.
//   Each stage has its own valid bit and loads whenever the stage after it
//   is empty or moving, so bubbles close up during a receiver stall.
//   When m_ready stays low the pipeline fills, then s_ready drops; nothing
//   is dropped or duplicated.
//   Synchronous active-low reset clears the valid bits only; the data
//   registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module accessory_auth_response (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  wire aar_pkg::req_t  s_data,
    output logic             m_valid,
    input  wire              m_ready,
    output aar_pkg::resp_t   m_data
);
    import aar_pkg::*;

    logic   v1_reg, v2_reg, v3_reg;
    logic   en1, en2, en3;
    area_t  area1_next, area1_reg;
    area_t  area2_reg;
    logic [7:0] chk_next, chk2_reg;
    resp_t  resp_next, resp3_reg;

    assign en3 = !v3_reg || m_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_ready = en1;
    assign m_valid = v3_reg;
    assign m_data  = resp3_reg;

    aar_mix u_mix (
        .req  (s_data),
        .area (area1_next)
    );

    always_comb begin
        chk_next = '0;
        for (int i = 0; i < AreaBytes; i++) begin
            chk_next = chk_next ^ area1_reg[i];
        end
    end

    aar_combine u_combine (
        .area (area2_reg),
        .chk  (chk2_reg),
        .resp (resp_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && s_valid) begin
            area1_reg <= area1_next;
        end
        if (en2 && v1_reg) begin
            area2_reg <= area1_reg;
            chk2_reg  <= chk_next;
        end
        if (en3 && v2_reg) begin
            resp3_reg <= resp_next;
        end
    end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accessory_auth_response testbench
// Sends directed request beats from a table, then four phases of random
// requests with different idle and stall rates on each side. Every response
// is checked against an in-bench model of the shift, mix, fold and combine
// steps, or against a value typed into the table.
// ----------------------------------------------------------------------------

module testbench;
    import aar_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int PhaseItems    = 450;
    localparam int NumDirected   = 16;

    // one row of the directed table: expected response is used only if known
    typedef struct packed {
        logic  known;
        resp_t rsp;
        req_t  req;
    } dir_row_t;

    // fields: known, response_high, response_low, challenge, type, serial
    dir_row_t dir_rows [NumDirected] = '{
        // all zero: every work byte zero, so every response byte is zero
        {1'b1, 64'h0, 64'h0, 32'h0, 32'h0, 64'h0},
        // all ones: check byte folds to zero, every byte ends as match code
        {1'b1, 64'h2c2c2c2c2c2c2c2c, 64'h2c2c2c2c2c2c2c2c,
            32'hffffffff, 32'hffffffff, 64'hffffffffffffffff},
        {1'b0, 128'h0, 32'h0, 32'h0, 64'hffffffffffffffff},
        {1'b0, 128'h0, 32'h0, 32'hffffffff, 64'h0},
        {1'b0, 128'h0, 32'hffffffff, 32'h0, 64'h0},
        // xor mix, both codes, offsets zero and seven
        {1'b0, 128'h0, 32'h013c08c3, 32'h5a5a5a5a, 64'h0123456789abcdef},
        {1'b0, 128'h0, 32'h02000f81, 32'hdeadbeef, 64'hfedcba9876543210},
        // or mix, both codes, offsets zero and seven
        {1'b0, 128'h0, 32'h04001122, 32'h12345678, 64'h55aa55aa55aa55aa},
        {1'b0, 128'h0, 32'h07f70018, 32'h87654321, 64'haa55aa55aa55aa55},
        // msb shifted out of every identity byte
        {1'b0, 128'h0, 32'h00000001, 32'h81818181, 64'h8181818181818181},
        {1'b0, 128'h0, 32'h0d0c0b0a, 32'h09080706, 64'h0504030201000f0e},
        // combine select patterns across the mirrored bytes
        {1'b0, 128'h0, 32'h06040200, 32'h06040200, 64'h0604020006040200},
        // zero bytes interleaved, checked for precedence over the match code
        {1'b0, 128'h0, 32'h00c00000, 32'h00ff00ff, 64'h00ff00ff00ff00ff},
        {1'b0, 128'h0, 32'h2c2c2c2c, 32'h2c2c2c2c, 64'h2c2c2c2c2c2c2c2c},
        {1'b0, 128'h0, 32'h80000080, 32'h80000000, 64'h8000000000000001},
        {1'b0, 128'h0, 32'h7f7f7f7f, 32'hfefefefe, 64'h0000000000000000}
    };

    logic  aclk    = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    req_t  s_data  = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    resp_t m_data;

    resp_t pending_responses [$];
    int    mismatches = 0;
    int    idle_cycles = 0;
    int    gap_pct = 0;
    int    stall_pct = 0;

    always #5 aclk = ~aclk;

    accessory_auth_response dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    function automatic resp_t calc_auth_response(input req_t r);
        area_t      orig;
        area_t      work;
        area_t      outb;
        logic [7:0] chk;
        logic [7:0] comb;
        logic [2:0] off;
        logic [1:0] sel;
        resp_t      res;
        orig = area_t'(r);
        work = orig;
        for (int i = 0; i < ShiftBytes; i++) begin
            if (orig[i+1][0])
                work[i] = {orig[i][6:0], 1'b0};
        end
        if (work[15][1:0] == MIX_XOR_A || work[15][1:0] == MIX_XOR_B) begin
            off = work[13][2:0];
            for (int k = 0; k < ChalBytes; k++)
                work[k + off] = work[k + off] ^ work[ChalBase + k];
        end else begin
            off = work[14][2:0];
            for (int k = 0; k < ChalBytes; k++)
                work[k + off] = work[k + off] | work[ChalBase + k];
        end
        chk = '0;
        for (int i = 0; i < AreaBytes; i++)
            chk = chk ^ work[i];
        for (int i = 0; i < AreaBytes; i++) begin
            sel = work[AreaBytes-1-i][2:1];
            case (sel)
                SEL_OR:  comb = work[i] | chk;
                SEL_AND: comb = work[i] & chk;
                default: comb = work[i] ^ chk;
            endcase
            if (comb == chk)
                comb = MATCH_CODE;
            if (work[i] == 8'h00)
                comb = 8'h00;
            outb[i] = comb;
        end
        res.response_low  = outb[7:0];
        res.response_high = outb[15:8];
        return res;
    endfunction

    // biased toward zero, all-ones, msb-only and lsb-only bytes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h80;
            3:       return 8'h01;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_request(input req_t r, input resp_t rsp);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < gap_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        pending_responses.push_back(rsp);
    endtask

    task automatic drain_responses();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_responses.size() != 0);
    endtask

    // response checker, receiver stalls and watchdog
    always @(posedge aclk) begin
        resp_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                if (pending_responses.size() == 0) begin
                    $display("%0t: unexpected response beat %h", $time, m_data);
                    mismatches++;
                end else begin
                    want = pending_responses.pop_front();
                    if (m_data.response_low !== want.response_low) begin
                        $display("%0t: response_low expected %h got %h",
                                 $time, want.response_low, m_data.response_low);
                        mismatches++;
                    end
                    if (m_data.response_high !== want.response_high) begin
                        $display("%0t: response_high expected %h got %h",
                                 $time, want.response_high, m_data.response_high);
                        mismatches++;
                    end
                end
            end
            if (idle_cycles >= WatchdogLimit) begin
                $display("%0t: watchdog expired", $time);
                $display("FAIL");
                $finish;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial begin
        int    gap_sched [4];
        int    stall_sched [4];
        area_t bytes;
        req_t  r;
        gap_sched   = '{0, 73, 0, 29};
        stall_sched = '{0, 0, 73, 29};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int n = 0; n < NumDirected; n++) begin
            if (dir_rows[n].known)
                send_request(dir_rows[n].req, dir_rows[n].rsp);
            else
                send_request(dir_rows[n].req, calc_auth_response(dir_rows[n].req));
        end

        for (int p = 0; p < 4; p++) begin
            // hold the sender off until the pipeline has fully emptied
            drain_responses();
            gap_pct   = gap_sched[p];
            stall_pct = stall_sched[p];
            for (int n = 0; n < PhaseItems; n++) begin
                for (int b = 0; b < AreaBytes; b++)
                    bytes[b] = pick_byte();
                r = req_t'(bytes);
                send_request(r, calc_auth_response(r));
            end
        end

        gap_pct   = 0;
        stall_pct = 0;
        drain_responses();
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
